### sv/desi_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the dual emitter safety interlock.
// Used by desi_cfg_regs, desi_core and dual_emitter_safety_interlock_unit.
package desi_pkg;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_ON_ONE  = 3'd1,
        OP_ON_TWO  = 3'd2,
        OP_OFF_ONE = 3'd3,
        OP_OFF_TWO = 3'd4,
        OP_OFF_ALL = 3'd5,
        OP_ESTOP   = 3'd6,
        OP_CLEAR   = 3'd7
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMERG   = 3'd1,
        ST_BAD_CUR = 3'd2,
        ST_THERMAL = 3'd3,
        ST_BUDGET  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_HELD    = 2'd1,
        EV_CLEARED = 2'd2
    } t_thermal_event;

    typedef enum logic [2:0] {
        CFG_DEF_ONE   = 3'd0,
        CFG_DEF_TWO   = 3'd1,
        CFG_ABS_LIMIT = 3'd2,
        CFG_TEMP_LIM  = 3'd3,
        CFG_TEMP_EN   = 3'd4,
        CFG_BUDGET    = 3'd5
    } t_cfg_index;

    localparam int CUR_W  = 11;
    localparam int TEMP_W = 15;
    localparam int TLIM_W = 10;
    localparam int ACC_W  = 32;

    localparam logic [CUR_W-1:0]  RST_DEF_CUR   = 11'd300;
    localparam logic [CUR_W-1:0]  RST_ABS_LIMIT = 11'd1000;
    localparam logic [TLIM_W-1:0] RST_TEMP_LIM  = 10'd700;
    localparam logic [ACC_W-1:0]  RST_BUDGET    = 32'd60000;

    localparam logic signed [TEMP_W:0] TEMP_INVALID = -16'sd1000;
    localparam logic signed [TEMP_W:0] TEMP_HYST    = 16'sd50;

    typedef struct packed {
        logic [CUR_W-1:0]  def_cur_one;
        logic [CUR_W-1:0]  def_cur_two;
        logic [CUR_W-1:0]  abs_limit;
        logic [TLIM_W-1:0] temp_limit;
        logic              temp_en;
        logic [ACC_W-1:0]  budget;
    } t_cfg;

    typedef struct packed {
        t_status          status;
        logic             one_on;
        logic [CUR_W-1:0] one_cur;
        logic             two_on;
        logic [CUR_W-1:0] two_cur;
        logic             throttled;
        t_thermal_event   event_code;
        logic             emerg;
        logic [ACC_W-1:0] acc;
    } t_result;

endpackage

### sv/desi_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file for the safety interlock.
// Depends on desi_pkg for the register indexes, reset values and t_cfg.
module desi_cfg_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  logic [2:0]      i_index,
    input  logic [31:0]     i_data,
    output desi_pkg::t_cfg  o_cfg
);

    desi_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.def_cur_one <= desi_pkg::RST_DEF_CUR;
            r_cfg.def_cur_two <= desi_pkg::RST_DEF_CUR;
            r_cfg.abs_limit   <= desi_pkg::RST_ABS_LIMIT;
            r_cfg.temp_limit  <= desi_pkg::RST_TEMP_LIM;
            r_cfg.temp_en     <= 1'b1;
            r_cfg.budget      <= desi_pkg::RST_BUDGET;
        end else if (i_wr) begin
            case (desi_pkg::t_cfg_index'(i_index))
                desi_pkg::CFG_DEF_ONE:   r_cfg.def_cur_one <= i_data[desi_pkg::CUR_W-1:0];
                desi_pkg::CFG_DEF_TWO:   r_cfg.def_cur_two <= i_data[desi_pkg::CUR_W-1:0];
                desi_pkg::CFG_ABS_LIMIT: r_cfg.abs_limit   <= i_data[desi_pkg::CUR_W-1:0];
                desi_pkg::CFG_TEMP_LIM:  r_cfg.temp_limit  <= i_data[desi_pkg::TLIM_W-1:0];
                desi_pkg::CFG_TEMP_EN:   r_cfg.temp_en     <= i_data[0];
                desi_pkg::CFG_BUDGET:    r_cfg.budget      <= i_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### sv/desi_core.sv
`timescale 1ns / 1ps
// Interlock state and single-pass command update: checks, counters, thermal hysteresis.
// Depends on desi_pkg for opcodes, status codes, t_cfg and t_result.
module desi_core #(
    parameter int COUNTER_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_fire,
    input  desi_pkg::t_opcode                  i_op,
    input  logic [desi_pkg::CUR_W-1:0]         i_req,
    input  logic signed [desi_pkg::TEMP_W-1:0] i_temp,
    input  desi_pkg::t_cfg                     i_cfg,
    output desi_pkg::t_result                  o_result
);

    localparam int CW   = COUNTER_BITS;
    localparam int WIDE = (CW > desi_pkg::ACC_W) ? CW : desi_pkg::ACC_W;

    logic                       r_emerg, n_emerg;
    logic                       r_act1, n_act1;
    logic                       r_act2, n_act2;
    logic [desi_pkg::CUR_W-1:0] r_lvl1, n_lvl1;
    logic [desi_pkg::CUR_W-1:0] r_lvl2, n_lvl2;
    logic [CW-1:0]              r_el1, n_el1;
    logic [CW-1:0]              r_el2, n_el2;
    logic [CW-1:0]              r_total, n_total;
    logic                       r_throttle, n_throttle;

    logic                                is_two;
    logic [desi_pkg::CUR_W-1:0]          cur;
    logic                                cur_bad;
    logic signed [desi_pkg::TEMP_W:0]    temp_x;
    logic signed [desi_pkg::TEMP_W:0]    lim_x;
    logic                                th_check, th_fail, th_clear;
    logic [WIDE-1:0]                     total_w;
    logic [WIDE-1:0]                     wide_sat;
    logic                                over_budget;
    logic [CW-1:0]                       el1_inc, el2_inc;
    logic                                off1, off2;
    logic [CW+1:0]                       off_sum;
    logic [CW-1:0]                       total_off;
    desi_pkg::t_status                   status;
    desi_pkg::t_thermal_event            ev;

    assign is_two  = (i_op == desi_pkg::OP_ON_TWO);
    assign cur     = (i_req != '0) ? i_req : (is_two ? i_cfg.def_cur_two : i_cfg.def_cur_one);
    assign cur_bad = (cur == '0) || (cur > i_cfg.abs_limit);

    assign temp_x   = {i_temp[desi_pkg::TEMP_W-1], i_temp};
    assign lim_x    = $signed({{(desi_pkg::TEMP_W + 1 - desi_pkg::TLIM_W){1'b0}},
                               i_cfg.temp_limit});
    assign th_check = i_cfg.temp_en && !(temp_x < desi_pkg::TEMP_INVALID);
    assign th_fail  = th_check && (temp_x >= lim_x);
    assign th_clear = th_check && !(temp_x >= lim_x) && r_throttle
                      && (temp_x < (lim_x - desi_pkg::TEMP_HYST));

    assign total_w     = WIDE'(r_total);
    assign over_budget = total_w > WIDE'(i_cfg.budget);

    assign el1_inc = (&r_el1) ? r_el1 : r_el1 + 1'b1;
    assign el2_inc = (&r_el2) ? r_el2 : r_el2 + 1'b1;

    assign off1      = r_act1 && (i_op == desi_pkg::OP_OFF_ONE || i_op == desi_pkg::OP_OFF_ALL);
    assign off2      = r_act2 && (i_op == desi_pkg::OP_OFF_TWO || i_op == desi_pkg::OP_OFF_ALL);
    assign off_sum   = (CW+2)'(r_total) + (off1 ? (CW+2)'(r_el1) : '0)
                     + (off2 ? (CW+2)'(r_el2) : '0);
    assign total_off = (|off_sum[CW+1:CW]) ? '1 : off_sum[CW-1:0];

    always_comb begin
        n_emerg    = r_emerg;
        n_act1     = r_act1;
        n_act2     = r_act2;
        n_lvl1     = r_lvl1;
        n_lvl2     = r_lvl2;
        n_el1      = r_el1;
        n_el2      = r_el2;
        n_total    = r_total;
        n_throttle = r_throttle;
        status     = desi_pkg::ST_OK;
        ev         = desi_pkg::EV_NONE;
        case (i_op)
            desi_pkg::OP_TICK: begin
                if (r_act1) n_el1 = el1_inc;
                if (r_act2) n_el2 = el2_inc;
            end
            desi_pkg::OP_ON_ONE, desi_pkg::OP_ON_TWO: begin
                if (r_emerg) begin
                    status = desi_pkg::ST_EMERG;
                end else if (cur_bad) begin
                    status = desi_pkg::ST_BAD_CUR;
                end else begin
                    if (th_fail) begin
                        n_throttle = 1'b1;
                        ev         = desi_pkg::EV_HELD;
                    end else if (th_clear) begin
                        n_throttle = 1'b0;
                        ev         = desi_pkg::EV_CLEARED;
                    end
                    if (th_fail) begin
                        status = desi_pkg::ST_THERMAL;
                    end else if (over_budget) begin
                        status = desi_pkg::ST_BUDGET;
                    end else if (is_two) begin
                        n_act2 = 1'b1;
                        n_lvl2 = cur;
                        n_el2  = '0;
                    end else begin
                        n_act1 = 1'b1;
                        n_lvl1 = cur;
                        n_el1  = '0;
                    end
                end
            end
            desi_pkg::OP_OFF_ONE, desi_pkg::OP_OFF_TWO, desi_pkg::OP_OFF_ALL: begin
                n_total = total_off;
                if (i_op != desi_pkg::OP_OFF_TWO) begin
                    n_act1 = 1'b0;
                    n_lvl1 = '0;
                    n_el1  = '0;
                end
                if (i_op != desi_pkg::OP_OFF_ONE) begin
                    n_act2 = 1'b0;
                    n_lvl2 = '0;
                    n_el2  = '0;
                end
            end
            desi_pkg::OP_ESTOP: begin
                n_emerg = 1'b1;
                n_act1  = 1'b0;
                n_act2  = 1'b0;
                n_lvl1  = '0;
                n_lvl2  = '0;
                n_el1   = '0;
                n_el2   = '0;
            end
            desi_pkg::OP_CLEAR: begin
                n_total = '0;
            end
            default: begin
            end
        endcase
    end

    assign wide_sat = WIDE'(n_total);

    always_comb begin
        o_result.status     = status;
        o_result.one_on     = n_act1;
        o_result.one_cur    = n_act1 ? n_lvl1 : '0;
        o_result.two_on     = n_act2;
        o_result.two_cur    = n_act2 ? n_lvl2 : '0;
        o_result.throttled  = n_throttle;
        o_result.event_code = ev;
        o_result.emerg      = n_emerg;
        o_result.acc        = (wide_sat > WIDE'({desi_pkg::ACC_W{1'b1}}))
                              ? '1 : wide_sat[desi_pkg::ACC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emerg    <= 1'b0;
            r_act1     <= 1'b0;
            r_act2     <= 1'b0;
            r_lvl1     <= '0;
            r_lvl2     <= '0;
            r_el1      <= '0;
            r_el2      <= '0;
            r_total    <= '0;
            r_throttle <= 1'b0;
        end else if (i_fire) begin
            r_emerg    <= n_emerg;
            r_act1     <= n_act1;
            r_act2     <= n_act2;
            r_lvl1     <= n_lvl1;
            r_lvl2     <= n_lvl2;
            r_el1      <= n_el1;
            r_el2      <= n_el2;
            r_total    <= n_total;
            r_throttle <= n_throttle;
        end
    end

endmodule

### sv/dual_emitter_safety_interlock_unit.sv
`timescale 1ns / 1ps
// Dual emitter safety interlock: one command in, one result out, one command per clock
// while the output is not stalled. A command passes an input register, is applied to the
// interlock state in a single pass and its result waits in an output register, which it
// leaves at an edge when the output is not stalled. Throughput is one command per cycle
// while the output is not stalled; desi_core updates the state in a single pass. The
// configuration port is always ready; write it only while no command is in flight.
// Depends on desi_pkg, desi_cfg_regs and desi_core.
module dual_emitter_safety_interlock_unit #(
    parameter int COUNTER_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [2:0]                         i_opcode,
    input  logic [desi_pkg::CUR_W-1:0]         i_request_current,
    input  logic signed [desi_pkg::TEMP_W-1:0] i_temperature,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [2:0]                         o_status,
    output logic                               o_drive_one_on,
    output logic [desi_pkg::CUR_W-1:0]         o_drive_one_current,
    output logic                               o_drive_two_on,
    output logic [desi_pkg::CUR_W-1:0]         o_drive_two_current,
    output logic                               o_throttled,
    output logic [1:0]                         o_thermal_event,
    output logic                               o_emergency_latched,
    output logic [desi_pkg::ACC_W-1:0]         o_accumulated_on_time,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [2:0]                         i_cfg_index,
    input  logic [31:0]                        i_cfg_data
);

    logic                               r_in_valid;
    logic [2:0]                         r_op;
    logic [desi_pkg::CUR_W-1:0]         r_req;
    logic signed [desi_pkg::TEMP_W-1:0] r_temp;
    logic                               r_out_valid;
    desi_pkg::t_result                  r_out;

    logic              out_free;
    logic              fire;
    logic              in_load;
    desi_pkg::t_cfg    cfg;
    desi_pkg::t_result result;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_load    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    desi_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    desi_core #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_op     (desi_pkg::t_opcode'(r_op)),
        .i_req    (r_req),
        .i_temp   (r_temp),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_load) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_op   <= i_opcode;
            r_req  <= i_request_current;
            r_temp <= i_temperature;
        end
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_status              = r_out.status;
    assign o_drive_one_on        = r_out.one_on;
    assign o_drive_one_current   = r_out.one_cur;
    assign o_drive_two_on        = r_out.two_on;
    assign o_drive_two_current   = r_out.two_cur;
    assign o_throttled           = r_out.throttled;
    assign o_thermal_event       = r_out.event_code;
    assign o_emergency_latched   = r_out.emerg;
    assign o_accumulated_on_time = r_out.acc;

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_out_valid)
        else $error("command left the input register without a result");

    a_emerg_forces_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_emergency_latched |-> !o_drive_one_on && !o_drive_two_on)
        else $error("channel on while emergency latched");

    a_off_means_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_drive_one_on && !o_drive_two_on
        |-> o_drive_one_current == '0 && o_drive_two_current == '0)
        else $error("drive current on an inactive channel");

    a_thermal_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == 3'(desi_pkg::ST_THERMAL)
        |-> o_throttled && o_thermal_event == 2'(desi_pkg::EV_HELD))
        else $error("thermal refusal without throttle");

endmodule

### sim/desi_interlock_checker.sv
`timescale 1ns / 1ps
// Scoreboard for dual_emitter_safety_interlock_unit: follows configuration writes and command
// transfers, predicts each result and compares it field by field with the output transfer.
// Depends on desi_pkg.
module desi_interlock_checker #(
    parameter int COUNTER_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic [2:0]                         i_opcode,
    input  logic [desi_pkg::CUR_W-1:0]         i_request_current,
    input  logic signed [desi_pkg::TEMP_W-1:0] i_temperature,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic [2:0]                         i_status,
    input  logic                               i_drive_one_on,
    input  logic [desi_pkg::CUR_W-1:0]         i_drive_one_current,
    input  logic                               i_drive_two_on,
    input  logic [desi_pkg::CUR_W-1:0]         i_drive_two_current,
    input  logic                               i_throttled,
    input  logic [1:0]                         i_thermal_event,
    input  logic                               i_emergency_latched,
    input  logic [desi_pkg::ACC_W-1:0]         i_accumulated_on_time,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [2:0]                         i_cfg_index,
    input  logic [31:0]                        i_cfg_data,
    output int                                 o_error_count,
    output int                                 o_results_pending
);

    typedef logic [COUNTER_BITS-1:0] t_count;

    logic [desi_pkg::CUR_W-1:0]  def_one;
    logic [desi_pkg::CUR_W-1:0]  def_two;
    logic [desi_pkg::CUR_W-1:0]  abs_limit;
    logic [desi_pkg::TLIM_W-1:0] temp_limit;
    logic                        temp_en;
    logic [desi_pkg::ACC_W-1:0]  budget;

    logic                        latch;
    logic                        one_active;
    logic                        two_active;
    logic [desi_pkg::CUR_W-1:0]  one_level;
    logic [desi_pkg::CUR_W-1:0]  two_level;
    t_count                      one_elapsed;
    t_count                      two_elapsed;
    t_count                      total_time;
    logic                        throttle;

    desi_pkg::t_result expected_results[$];
    int                mismatches = 0;

    function automatic t_count sat_add(t_count a, t_count b);
        logic [COUNTER_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[COUNTER_BITS] ? '1 : sum[COUNTER_BITS-1:0];
    endfunction

    function automatic void reset_model();
        def_one     = desi_pkg::RST_DEF_CUR;
        def_two     = desi_pkg::RST_DEF_CUR;
        abs_limit   = desi_pkg::RST_ABS_LIMIT;
        temp_limit  = desi_pkg::RST_TEMP_LIM;
        temp_en     = 1'b1;
        budget      = desi_pkg::RST_BUDGET;
        latch       = 1'b0;
        one_active  = 1'b0;
        two_active  = 1'b0;
        one_level   = '0;
        two_level   = '0;
        one_elapsed = '0;
        two_elapsed = '0;
        total_time  = '0;
        throttle    = 1'b0;
        expected_results.delete();
    endfunction

    function automatic void write_setting(logic [2:0] idx, logic [31:0] data);
        case (idx)
            desi_pkg::CFG_DEF_ONE:   def_one    = data[desi_pkg::CUR_W-1:0];
            desi_pkg::CFG_DEF_TWO:   def_two    = data[desi_pkg::CUR_W-1:0];
            desi_pkg::CFG_ABS_LIMIT: abs_limit  = data[desi_pkg::CUR_W-1:0];
            desi_pkg::CFG_TEMP_LIM:  temp_limit = data[desi_pkg::TLIM_W-1:0];
            desi_pkg::CFG_TEMP_EN:   temp_en    = data[0];
            desi_pkg::CFG_BUDGET:    budget     = data;
            default: ;
        endcase
    endfunction

    function automatic desi_pkg::t_status try_activate(
            logic chan_two, logic [desi_pkg::CUR_W-1:0] req,
            logic signed [desi_pkg::TEMP_W-1:0] temp,
            output desi_pkg::t_thermal_event ev);
        logic [desi_pkg::CUR_W-1:0] cur;
        int t;
        int lim;
        ev  = desi_pkg::EV_NONE;
        cur = req;
        t   = temp;
        lim = int'(temp_limit);
        if (latch)
            return desi_pkg::ST_EMERG;
        if (cur == 0)
            cur = chan_two ? def_two : def_one;
        if (cur == 0 || cur > abs_limit)
            return desi_pkg::ST_BAD_CUR;
        if (temp_en && t >= int'(desi_pkg::TEMP_INVALID)) begin
            if (t >= lim) begin
                throttle = 1'b1;
                ev = desi_pkg::EV_HELD;
                return desi_pkg::ST_THERMAL;
            end
            if (throttle && t < lim - int'(desi_pkg::TEMP_HYST)) begin
                throttle = 1'b0;
                ev = desi_pkg::EV_CLEARED;
            end
        end
        if (64'(total_time) > 64'(budget))
            return desi_pkg::ST_BUDGET;
        if (chan_two) begin
            two_active  = 1'b1;
            two_level   = cur;
            two_elapsed = '0;
        end else begin
            one_active  = 1'b1;
            one_level   = cur;
            one_elapsed = '0;
        end
        return desi_pkg::ST_OK;
    endfunction

    function automatic void shut_one();
        if (one_active)
            total_time = sat_add(total_time, one_elapsed);
        one_active  = 1'b0;
        one_level   = '0;
        one_elapsed = '0;
    endfunction

    function automatic void shut_two();
        if (two_active)
            total_time = sat_add(total_time, two_elapsed);
        two_active  = 1'b0;
        two_level   = '0;
        two_elapsed = '0;
    endfunction

    function automatic desi_pkg::t_result apply_command(
            desi_pkg::t_opcode op, logic [desi_pkg::CUR_W-1:0] req,
            logic signed [desi_pkg::TEMP_W-1:0] temp);
        desi_pkg::t_result        r;
        desi_pkg::t_status        st;
        desi_pkg::t_thermal_event ev;
        st = desi_pkg::ST_OK;
        ev = desi_pkg::EV_NONE;
        case (op)
            desi_pkg::OP_TICK: begin
                if (one_active)
                    one_elapsed = sat_add(one_elapsed, t_count'(1));
                if (two_active)
                    two_elapsed = sat_add(two_elapsed, t_count'(1));
            end
            desi_pkg::OP_ON_ONE:  st = try_activate(1'b0, req, temp, ev);
            desi_pkg::OP_ON_TWO:  st = try_activate(1'b1, req, temp, ev);
            desi_pkg::OP_OFF_ONE: shut_one();
            desi_pkg::OP_OFF_TWO: shut_two();
            desi_pkg::OP_OFF_ALL: begin
                shut_one();
                shut_two();
            end
            desi_pkg::OP_ESTOP: begin
                latch       = 1'b1;
                one_active  = 1'b0;
                two_active  = 1'b0;
                one_level   = '0;
                two_level   = '0;
                one_elapsed = '0;
                two_elapsed = '0;
            end
            default: total_time = '0;
        endcase
        r.status     = st;
        r.one_on     = one_active;
        r.one_cur    = one_active ? one_level : '0;
        r.two_on     = two_active;
        r.two_cur    = two_active ? two_level : '0;
        r.throttled  = throttle;
        r.event_code = ev;
        r.emerg      = latch;
        r.acc        = (64'(total_time) > 64'({desi_pkg::ACC_W{1'b1}}))
                       ? '1 : desi_pkg::ACC_W'(total_time);
        return r;
    endfunction

    function automatic void compare_field(string name, logic [desi_pkg::ACC_W-1:0] want,
                                          logic [desi_pkg::ACC_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        desi_pkg::t_result want;
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                write_setting(i_cfg_index, i_cfg_data);
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(apply_command(desi_pkg::t_opcode'(i_opcode),
                                                         i_request_current, i_temperature));
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: result transfer expected none actual status %0d",
                             $time, i_status);
                end else begin
                    want = expected_results.pop_front();
                    compare_field("status", want.status, i_status);
                    compare_field("drive_one_on", want.one_on, i_drive_one_on);
                    compare_field("drive_one_current", want.one_cur, i_drive_one_current);
                    compare_field("drive_two_on", want.two_on, i_drive_two_on);
                    compare_field("drive_two_current", want.two_cur, i_drive_two_current);
                    compare_field("throttled", want.throttled, i_throttled);
                    compare_field("thermal_event", want.event_code, i_thermal_event);
                    compare_field("emergency_latched", want.emerg, i_emergency_latched);
                    compare_field("accumulated_on_time", want.acc, i_accumulated_on_time);
                end
            end
        end
        o_error_count     <= mismatches;
        o_results_pending <= expected_results.size();
    end

endmodule

### sim/dual_emitter_safety_interlock_unit_test.sv
`timescale 1ns / 1ps
// Testbench top for dual_emitter_safety_interlock_unit: drives commands, register writes
// and output stalls, and gives the verdict; desi_interlock_checker predicts and compares.
// Depends on desi_pkg, the block RTL and sim/desi_interlock_checker.sv.
module dual_emitter_safety_interlock_unit_test;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 100;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    typedef struct {
        desi_pkg::t_opcode                  op;
        logic [desi_pkg::CUR_W-1:0]         cur;
        logic signed [desi_pkg::TEMP_W-1:0] temp;
    } t_command;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_stall;
    logic [2:0]                         i_opcode = '0;
    logic [desi_pkg::CUR_W-1:0]         i_request_current = '0;
    logic signed [desi_pkg::TEMP_W-1:0] i_temperature = '0;
    logic                               o_out_valid;
    logic                               i_out_stall = 1'b0;
    logic [2:0]                         o_status;
    logic                               o_drive_one_on;
    logic [desi_pkg::CUR_W-1:0]         o_drive_one_current;
    logic                               o_drive_two_on;
    logic [desi_pkg::CUR_W-1:0]         o_drive_two_current;
    logic                               o_throttled;
    logic [1:0]                         o_thermal_event;
    logic                               o_emergency_latched;
    logic [desi_pkg::ACC_W-1:0]         o_accumulated_on_time;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [2:0]                         i_cfg_index = '0;
    logic [31:0]                        i_cfg_data = '0;

    int error_count;
    int results_pending;
    int cycle_count = 0;
    int send_mode = 0;
    int stall_mode = 0;
    int stall_left = 0;
    int cur_limit_now = desi_pkg::RST_ABS_LIMIT;
    int temp_limit_now = desi_pkg::RST_TEMP_LIM;

    always #2 i_clk = ~i_clk;

    dual_emitter_safety_interlock_unit DUT (.*);

    desi_interlock_checker CHECK (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .i_in_stall            (o_in_stall),
        .i_opcode              (i_opcode),
        .i_request_current     (i_request_current),
        .i_temperature         (i_temperature),
        .i_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .i_status              (o_status),
        .i_drive_one_on        (o_drive_one_on),
        .i_drive_one_current   (o_drive_one_current),
        .i_drive_two_on        (o_drive_two_on),
        .i_drive_two_current   (o_drive_two_current),
        .i_throttled           (o_throttled),
        .i_thermal_event       (o_thermal_event),
        .i_emergency_latched   (o_emergency_latched),
        .i_accumulated_on_time (o_accumulated_on_time),
        .i_cfg_valid           (i_cfg_valid),
        .i_cfg_ready           (o_cfg_ready),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .o_error_count         (error_count),
        .o_results_pending     (results_pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** dual_emitter_safety_interlock_unit: FAILED **");
            $finish;
        end
    end

    // output stall: short bursts, occasionally long holds
    always @(posedge i_clk) begin
        int r;
        if (!i_rst_n || stall_mode == 0) begin
            i_out_stall <= 1'b0;
        end else if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                i_out_stall <= 1'b0;
            end else if (r < 95) begin
                i_out_stall <= 1'b1;
                stall_left <= $urandom_range(0, 2);
            end else begin
                i_out_stall <= 1'b1;
                stall_left <= $urandom_range(8, 40);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (send_mode == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_command(t_command c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_opcode          <= c.op;
        i_request_current <= c.cur;
        i_temperature     <= c.temp;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic issue(desi_pkg::t_opcode op, int cur, int temp);
        t_command c;
        c.op   = op;
        c.cur  = desi_pkg::CUR_W'(cur);
        c.temp = desi_pkg::TEMP_W'(temp);
        send_command(c);
    endtask

    function automatic t_command random_command(bit with_estop);
        t_command c;
        int r;
        int k;
        int t;
        r = $urandom_range(0, 99);
        if (r < 34)      c.op = desi_pkg::OP_TICK;
        else if (r < 50) c.op = desi_pkg::OP_ON_ONE;
        else if (r < 66) c.op = desi_pkg::OP_ON_TWO;
        else if (r < 74) c.op = desi_pkg::OP_OFF_ONE;
        else if (r < 82) c.op = desi_pkg::OP_OFF_TWO;
        else if (r < 88) c.op = desi_pkg::OP_OFF_ALL;
        else if (r < 92) c.op = desi_pkg::OP_CLEAR;
        else             c.op = with_estop ? desi_pkg::OP_ESTOP : desi_pkg::OP_TICK;
        case ($urandom_range(0, 9))
            0, 1, 2: k = 0;
            3, 4:    k = cur_limit_now + int'($urandom_range(0, 4)) - 2;
            default: k = $urandom_range(0, 2047);
        endcase
        if (k < 0)
            k = 0;
        if (k > 2047)
            k = 2047;
        case ($urandom_range(0, 9))
            0, 1:       t = int'($urandom_range(0, 32767)) - 16384;
            2, 3, 4, 5: t = temp_limit_now + int'($urandom_range(0, 100)) - 70;
            6:          t = temp_limit_now - 50 + int'($urandom_range(0, 6)) - 3;
            7:          t = -1000 + int'($urandom_range(0, 4)) - 2;
            default:    t = int'($urandom_range(0, 500)) - 200;
        endcase
        c.cur  = desi_pkg::CUR_W'(k);
        c.temp = desi_pkg::TEMP_W'(t);
        return c;
    endfunction

    // hold valid until the transfer; the caller drops it after the batch
    task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic program_settings(int p);
        logic [31:0] d1;
        logic [31:0] d2;
        logic [31:0] ab;
        logic [31:0] tl;
        logic [31:0] en;
        logic [31:0] bud;
        case (p)
            0: begin
                d1 = 0; d2 = 2047; ab = 2047; tl = 300; en = 1; bud = 0;
            end
            1: begin
                d1 = 1; d2 = 1; ab = 1; tl = 800; en = 0; bud = 32'hFFFF_FFFF;
            end
            2: begin
                d1 = $urandom_range(1, 1000); d2 = 0; ab = 1000; tl = 1023; en = 1;
                bud = $urandom_range(0, 50);
            end
            default: begin
                d1  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 1500);
                d2  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 1500);
                ab  = $urandom_range(1, 2047);
                tl  = $urandom_range(300, 800);
                en  = 32'(($urandom_range(0, 3) != 0));
                bud = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 400);
            end
        endcase
        cfg_write(desi_pkg::CFG_DEF_ONE, ($urandom & ~32'h7FF) | d1);
        cfg_write(CFG_SPARE_LO, $urandom);
        cfg_write(desi_pkg::CFG_DEF_TWO, ($urandom & ~32'h7FF) | d2);
        cfg_write(desi_pkg::CFG_ABS_LIMIT, ($urandom & ~32'h7FF) | ab);
        cfg_write(desi_pkg::CFG_TEMP_LIM, ($urandom & ~32'h3FF) | tl);
        cfg_write(CFG_SPARE_HI, $urandom);
        cfg_write(desi_pkg::CFG_TEMP_EN, ($urandom & ~32'h1) | en);
        cfg_write(desi_pkg::CFG_BUDGET, bud);
        i_cfg_valid <= 1'b0;
        cur_limit_now  = int'(ab[desi_pkg::CUR_W-1:0]);
        temp_limit_now = int'(tl[desi_pkg::TLIM_W-1:0]);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        issue(desi_pkg::OP_TICK, 0, 0);
        issue(desi_pkg::OP_ON_ONE, 0, 250);
        issue(desi_pkg::OP_TICK, 0, 0);
        issue(desi_pkg::OP_TICK, 0, 0);
        issue(desi_pkg::OP_ON_TWO, 1000, 699);
        issue(desi_pkg::OP_ON_TWO, 1001, 0);
        issue(desi_pkg::OP_ON_ONE, 2047, 0);
        issue(desi_pkg::OP_ON_ONE, 500, 700);
        issue(desi_pkg::OP_ON_ONE, 500, 660);
        issue(desi_pkg::OP_ON_TWO, 1, 649);
        issue(desi_pkg::OP_TICK, 0, 0);
        issue(desi_pkg::OP_ON_ONE, 0, -1001);
        issue(desi_pkg::OP_ON_ONE, 0, 16383);
        issue(desi_pkg::OP_ON_TWO, 0, -16384);
        issue(desi_pkg::OP_ON_ONE, 0, -1000);
        issue(desi_pkg::OP_TICK, 0, 0);
        issue(desi_pkg::OP_OFF_ONE, 0, 0);
        issue(desi_pkg::OP_OFF_ONE, 0, 0);
        issue(desi_pkg::OP_OFF_TWO, 0, 0);
        issue(desi_pkg::OP_ON_TWO, 300, 0);
        issue(desi_pkg::OP_TICK, 0, 0);
        issue(desi_pkg::OP_OFF_ALL, 0, 0);
        issue(desi_pkg::OP_OFF_ALL, 0, 0);
        issue(desi_pkg::OP_CLEAR, 0, 0);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            program_settings(p);
            send_mode  = $urandom_range(0, 2);
            stall_mode = $urandom_range(0, 2);
            repeat (PHASE_ITEMS) send_command(random_command(1'b0));
            drain();
        end

        // latch the emergency stop last: only reset clears it
        send_mode  = 1;
        stall_mode = 1;
        repeat (10) send_command(random_command(1'b0));
        issue(desi_pkg::OP_ESTOP, 0, 0);
        issue(desi_pkg::OP_ESTOP, 0, 0);
        repeat (25) send_command(random_command(1'b1));
        drain();

        if (error_count == 0)
            $display("** dual_emitter_safety_interlock_unit: PASSED **");
        else
            $display("** dual_emitter_safety_interlock_unit: FAILED **");
        $finish;
    end

endmodule
